// File: rtl/core/assert_macros.svh
// Assertion macros shared by the smoothing core modules.
// No dependencies; modules pull this in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent property on the rising clock edge, off while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_PROP(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/fns_pkg.sv
// Shared types and constants of the four-neighbour smoothing core.
// No dependencies.
`default_nettype none
package fns_pkg;

	localparam int PIX_W      = 8;
	localparam int SUM_W      = PIX_W + 2;
	localparam int AVG_SHIFT  = 2;
	localparam int OUT_ROW_W  = 11;
	localparam int OUT_COL_W  = 11;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int MIN_SIZE   = 3;
	localparam int RUN_CNT_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 12'd1080;
	localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 12'd1920;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic [PIX_W-1:0]     value;
		logic                 last_of_run;
		logic                 frame_done;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/core/fns_orig_ram.sv
// Original-pixel line memory: one write port, two registered read ports.
// Depends on fns_pkg.
`default_nettype none
module fns_orig_ram
	import fns_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [PIX_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [PIX_W-1:0] rdata_a,
	output logic      [PIX_W-1:0] rdata_b
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// reads return the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/fns_smooth_ram.sv
// Smoothed-pixel line memory: one write port, one registered read port.
// Depends on fns_pkg.
`default_nettype none
module fns_smooth_ram
	import fns_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [PIX_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/fns_out_buf.sv
// Output register pair: holds the one or two results of an item and
// presents them in order. Depends on fns_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module fns_out_buf
	import fns_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire logic [RUN_CNT_W-1:0] cnt_in,
	input  wire res_t                 res0_in,
	input  wire res_t                 res1_in,
	output logic                      can_load,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output res_t                      head
);

	logic [RUN_CNT_W-1:0] cnt_q;
	res_t                 head_q;
	res_t                 tail_q;
	logic                 xfer;

	assign out_valid = (cnt_q != '0);
	assign xfer      = out_valid && out_ready;
	assign head      = head_q;
	// take a new run when the buffer is empty or drains this cycle
	assign can_load  = (cnt_q == '0) || ((cnt_q == RUN_CNT_W'(1)) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= cnt_in;
		end else if (xfer) begin
			cnt_q <= cnt_q - RUN_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= res0_in;
			tail_q <= res1_in;
		end else if (xfer) begin
			head_q <= tail_q;
		end
	end

	`ASSERT_NEVER(a_load_over_pair, clk, arst_n, load && (cnt_q == RUN_CNT_W'(2)))
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == RUN_CNT_W'(3))
	`ASSERT_PROP(a_pair_second, clk, arst_n,
		(xfer && (cnt_q == RUN_CNT_W'(2))) |=> (out_valid && !$past(load)))

endmodule
`default_nettype wire

// File: rtl/core/four_neighbour_smoothing_stream.sv
// An accepted pixel is registered in stage 1, then loaded into the output register pair.
// Throughput: one pixel per cycle while out_ready is high; a last-row pixel carries two
// results and holds the output pair until the first has left, so the last row runs slower.
// The rate is set by the single write port of each line memory and the output pair.
// Reset clears position, window and output control; sizes return to 1080 x 1920.
// Line memories are not cleared: every entry is written before the row below reads it.
`default_nettype none
`include "assert_macros.svh"
module four_neighbour_smoothing_stream
	import fns_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// pixel input channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [PIX_W-1:0]     pixel_in,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [OUT_ROW_W-1:0]      out_row,
	output logic [OUT_COL_W-1:0]      out_col,
	output logic [PIX_W-1:0]          out_value,
	output logic                      last_of_run,
	output logic                      frame_done
);

	// column and row counter widths, and widths for size compares
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WW0 = $clog2(MAX_WIDTH + 1);
	localparam int HW0 = $clog2(MAX_HEIGHT + 1);
	localparam int SW  = (WW0 > CFG_W) ? WW0 : CFG_W;
	localparam int SH  = (HW0 > CFG_W) ? HW0 : CFG_W;

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_FRAME_WIDTH;
			frame_height_q <= RESET_FRAME_HEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
			endcase
		end
	end

	// Clamp the sizes into the legal range: below three acts as three,
	// above MAX_WIDTH or MAX_HEIGHT acts as that maximum.
	logic [SW-1:0] w_raw, w_eff;
	logic [SH-1:0] h_raw, h_eff;

	always_comb begin
		w_raw = SW'(frame_width_q);
		h_raw = SH'(frame_height_q);
		if (w_raw < SW'(MIN_SIZE)) begin
			w_eff = SW'(MIN_SIZE);
		end else if (w_raw > SW'(MAX_WIDTH)) begin
			w_eff = SW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw < SH'(MIN_SIZE)) begin
			h_eff = SH'(MIN_SIZE);
		end else if (h_raw > SH'(MAX_HEIGHT)) begin
			h_eff = SH'(MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
	end

	// ------------------------------------------------- stage 0: position, reads
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	logic          move;
	logic          last_col, last_row, interior;

	assign accept = in_valid && in_ready;

	always_comb begin
		last_col = (SW'(col_q) + SW'(1)) >= w_eff;
		last_row = (SH'(row_q) + SH'(1)) >= h_eff;
		// interior means the emitted pixel (row-1, col) is off every border
		interior = (row_q > RW'(1)) && (SH'(row_q) < h_eff) && (col_q != '0)
			&& ((SW'(col_q) + SW'(1)) < w_eff);
	end

	// Advance the raster position; a shrunk size ends the row or frame early.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Original line: read centre and right of the row above while the
	// incoming pixel overwrites the centre entry (read returns old data).
	logic [PIX_W-1:0] centre_rd, right_rd, above_rd;

	fns_orig_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_orig (
		.clk     (clk),
		.we      (accept),
		.waddr   (col_q),
		.wdata   (pixel_in),
		.re      (accept),
		.raddr_a (col_q),
		.raddr_b (col_q + CW'(1)),
		.rdata_a (centre_rd),
		.rdata_b (right_rd)
	);

	// ----------------------------------------------------- stage 1: average
	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    col_s1;
	logic [RW-1:0]    row_s1;
	logic             has_above_s1;
	logic             interior_s1;
	logic             last_col_s1;
	logic             last_row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pixel_in;
			col_s1       <= col_q;
			row_s1       <= row_q;
			has_above_s1 <= (row_q != '0);
			interior_s1  <= interior;
			last_col_s1  <= last_col;
			last_row_s1  <= last_row;
		end
	end

	// Smoothed line: read the smoothed pixel above at accept, write the new
	// smoothed value back when the item leaves stage 1. The same entry is
	// read again only one full row later, so no forwarding is needed.
	logic [PIX_W-1:0] smooth_val;
	logic             smooth_we;

	assign smooth_we = move && has_above_s1;

	fns_smooth_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_smooth (
		.clk   (clk),
		.we    (smooth_we),
		.waddr (col_s1),
		.wdata (smooth_val),
		.re    (accept),
		.raddr (col_q),
		.rdata (above_rd)
	);

	// left neighbour: centre of the previous column, zero at a row start
	logic [PIX_W-1:0] left_q;
	logic [SUM_W-1:0] sum;

	always_comb begin
		sum = SUM_W'(above_rd) + SUM_W'(left_q) + SUM_W'(right_rd) + SUM_W'(pix_s1);
		smooth_val = interior_s1 ? PIX_W'(sum >> AVG_SHIFT) : centre_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (move) begin
			if (last_col_s1) begin
				left_q <= '0;
			end else if (has_above_s1) begin
				left_q <= centre_rd;
			end
		end
	end

	// ------------------------------------------------------------ results
	// Row above first (if any), then the last-row pass-through pixel.
	res_t                 res_above, res_own, res0, res1;
	logic [RUN_CNT_W-1:0] run_cnt;
	logic                 buf_can_load;
	res_t                 head;

	always_comb begin
		res_above.row         = OUT_ROW_W'(row_s1 - RW'(1));
		res_above.col         = OUT_COL_W'(col_s1);
		res_above.value       = smooth_val;
		res_above.last_of_run = !last_row_s1;
		res_above.frame_done  = 1'b0;

		res_own.row           = OUT_ROW_W'(row_s1);
		res_own.col           = OUT_COL_W'(col_s1);
		res_own.value         = pix_s1;
		res_own.last_of_run   = 1'b1;
		res_own.frame_done    = last_col_s1;

		res0    = has_above_s1 ? res_above : res_own;
		res1    = res_own;
		run_cnt = RUN_CNT_W'(has_above_s1) + RUN_CNT_W'(last_row_s1);
	end

	// drop a result-free item (first row) straight out of stage 1
	assign move     = valid_s1 && buf_can_load;
	assign in_ready = !valid_s1 || move;

	fns_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (move),
		.cnt_in    (run_cnt),
		.res0_in   (res0),
		.res1_in   (res1),
		.can_load  (buf_can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign out_row     = head.row;
	assign out_col     = head.col;
	assign out_value   = head.value;
	assign last_of_run = head.last_of_run;
	assign frame_done  = head.frame_done;

	`ASSERT_PROP(a_done_ends_run, clk, arst_n, (out_valid && frame_done) |-> last_of_run)
	`ASSERT_PROP(a_row_wrap, clk, arst_n, (accept && last_col) |=> (col_q == '0))
	`ASSERT_PROP(a_s1_from_accept, clk, arst_n, $rose(valid_s1) |-> $past(accept))
	`ASSERT_PROP(a_ready_when_moving, clk, arst_n, move |-> in_ready)

endmodule
`default_nettype wire

// File: tb/sv/tb_four_neighbour_smoothing_stream.sv
// Self-checking testbench for four_neighbour_smoothing_stream: random and directed frames,
// a predicting scoreboard class, random idling on both channels and one long output stall.
// Depends on fns_pkg and the four_neighbour_smoothing_stream RTL.
`default_nettype none
module tb_four_neighbour_smoothing_stream;
	import fns_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles to let pass after the last expected result before touching registers.
	localparam int SETTLE_CYCLES   = 10;
	// Long receiver hold-off: start it once this many pixels have gone in.
	localparam int PRESSURE_AT     = 60;
	localparam int PRESSURE_CYCLES = 300;
	// Bound on the final drain, in cycles.
	localparam int DRAIN_LIMIT     = 200000;

	// Predicts the smoothed stream and holds the results still owed by the block.
	class smoothing_scoreboard;
		localparam int LINE_DEPTH = 2048;
		localparam int ROW_LIMIT  = 2048;

		logic [PIX_W-1:0] smooth_row [LINE_DEPTH];
		logic [PIX_W-1:0] orig_row [LINE_DEPTH];
		logic [PIX_W-1:0] left_pix;
		int unsigned      row_pos;
		int unsigned      col_pos;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		res_t             expected_pixels [$];
		int unsigned      mismatches;
		int unsigned      pixels_in;
		int unsigned      results_seen;
		int unsigned      frames_seen;

		function void clear();
			for (int i = 0; i < LINE_DEPTH; i++) begin
				smooth_row[i] = '0;
				orig_row[i] = '0;
			end
			left_pix = '0;
			row_pos = 0;
			col_pos = 0;
			width_reg = RESET_FRAME_WIDTH;
			height_reg = RESET_FRAME_HEIGHT;
			expected_pixels.delete();
			mismatches = 0;
			pixels_in = 0;
			results_seen = 0;
			frames_seen = 0;
		endfunction

		function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
			if (v < MIN_SIZE)
				return MIN_SIZE;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function int unsigned frame_pixels();
			return clamp_size(width_reg, LINE_DEPTH) * clamp_size(height_reg, ROW_LIMIT);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_FRAME_WIDTH)
				width_reg = data;
			else if (idx == REG_FRAME_HEIGHT)
				height_reg = data;
		endfunction

		// Advance the predictor by one accepted pixel and queue what it emits.
		function void note_pixel(logic [PIX_W-1:0] p);
			int unsigned w;
			int unsigned h;
			int unsigned above;
			int unsigned sum;
			logic [PIX_W-1:0] val;
			logic last_col;
			logic last_row;
			res_t batch [2];
			int n;
			w = clamp_size(width_reg, LINE_DEPTH);
			h = clamp_size(height_reg, ROW_LIMIT);
			last_col = (col_pos + 1 >= w);
			last_row = (row_pos + 1 >= h);
			n = 0;
			pixels_in++;
			if (row_pos >= 1) begin
				above = row_pos - 1;
				if (above >= 1 && above + 1 < h && col_pos >= 1 && col_pos + 1 < w) begin
					sum = int'(smooth_row[col_pos]) + int'(left_pix)
						+ int'(orig_row[col_pos + 1]) + int'(p);
					val = PIX_W'(sum >> AVG_SHIFT);
				end else begin
					val = orig_row[col_pos];
				end
				left_pix = orig_row[col_pos];
				smooth_row[col_pos] = val;
				batch[n] = '{row: OUT_ROW_W'(above), col: OUT_COL_W'(col_pos), value: val,
					last_of_run: 1'b0, frame_done: 1'b0};
				n++;
			end
			orig_row[col_pos] = p;
			if (last_row) begin
				batch[n] = '{row: OUT_ROW_W'(row_pos), col: OUT_COL_W'(col_pos), value: p,
					last_of_run: 1'b0, frame_done: 1'b0};
				n++;
			end
			if (n > 0) begin
				batch[n - 1].last_of_run = 1'b1;
				batch[n - 1].frame_done = last_row && last_col;
			end
			for (int k = 0; k < n; k++)
				expected_pixels.push_back(batch[k]);
			if (last_col) begin
				col_pos = 0;
				left_pix = '0;
				row_pos = last_row ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			results_seen++;
			if (expected_pixels.size() == 0) begin
				$error("result row %0d col %0d value %0d arrived with nothing expected",
					got.row, got.col, got.value);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			if (got.frame_done)
				frames_seen++;
			if (got.row !== want.row) begin
				$error("out_row: expected %0d, actual %0d", want.row, got.row);
				mismatches++;
			end
			if (got.col !== want.col) begin
				$error("out_col: expected %0d, actual %0d", want.col, got.col);
				mismatches++;
			end
			if (got.value !== want.value) begin
				$error("out_value: expected %0d, actual %0d", want.value, got.value);
				mismatches++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, actual %0b", want.last_of_run,
					got.last_of_run);
				mismatches++;
			end
			if (got.frame_done !== want.frame_done) begin
				$error("frame_done: expected %0b, actual %0b", want.frame_done, got.frame_done);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [OUT_ROW_W-1:0] out_row;
	logic [OUT_COL_W-1:0] out_col;
	logic [PIX_W-1:0]     out_value;
	logic                 last_of_run;
	logic                 frame_done;

	smoothing_scoreboard sb = new();

	// Set in the closing part of the run: no idling on either side from then on.
	bit quiet = 1'b0;
	// Receiver state, owned by the receiver process only.
	int  stall_left = 0;
	bit  pressure_done = 1'b0;

	four_neighbour_smoothing_stream DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_value   (out_value),
		.last_of_run (last_of_run),
		.frame_done  (frame_done)
	);

	always #1ns clk = ~clk;

	// Hard stop well beyond the slowest legal run.
	initial begin
		#5_000_000ns;
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: check every result transfer, then pick the next ready level.
	// Outputs are sampled right after the edge, so they still hold their pre-edge values.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			res_t got;
			got.row = out_row;
			got.col = out_col;
			got.value = out_value;
			got.last_of_run = last_of_run;
			got.frame_done = frame_done;
			sb.check_result(got);
		end
		// One long hold-off so the line pipeline backs up into the input channel.
		if (!pressure_done && sb.pixels_in >= PRESSURE_AT) begin
			pressure_done = 1'b1;
			stall_left = PRESSURE_CYCLES;
		end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11);
		end
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Random pixel, leaning toward the two extremes.
	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Offer one pixel and hold it until the transfer. Valid is only dropped for a gap,
	// never dropped and raised in the same step.
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= p;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_pixel(p);
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both size registers on consecutive edges; the block must be idle.
	task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		sb.set_reg(REG_FRAME_WIDTH, w);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		sb.set_reg(REG_FRAME_HEIGHT, h);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_random_frame();
		int unsigned count;
		count = sb.frame_pixels();
		for (int unsigned i = 0; i < count; i++)
			send_pixel(rand_pixel());
	endtask

	// Small random sizes; now and then a size below the minimum, which acts as 3.
	task automatic random_phase();
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		int frames;
		w = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
			: CFG_W'($urandom_range(3, 10));
		h = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
			: CFG_W'($urandom_range(3, 8));
		frames = $urandom_range(1, 2);
		set_frame_size(w, h);
		// Back-to-back frames check the wrap from the last pixel to row 0.
		repeat (frames) send_random_frame();
		wait_idle();
	endtask

	initial begin
		logic [PIX_W-1:0] checker3 [9];
		checker3 = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame: one interior pixel, alternating extremes around it.
		set_frame_size(12'd3, 12'd3);
		foreach (checker3[i])
			send_pixel(checker3[i]);
		wait_idle();

		// All-white 4x4: the four-neighbour sum hits its top value.
		set_frame_size(12'd4, 12'd4);
		repeat (16) send_pixel(8'd255);
		wait_idle();

		// Wider line, with a height of zero that acts as 3; the long stall lands here.
		set_frame_size(12'd48, 12'd0);
		send_random_frame();
		wait_idle();

		// Width below the minimum, which acts as 3, over twelve rows.
		set_frame_size(12'd1, 12'd12);
		send_random_frame();
		wait_idle();

		// Bulk of the random stimulus in small frames.
		while (sb.pixels_in < 320)
			random_phase();

		// Closing part at full rate on both sides.
		quiet = 1'b1;
		do
			random_phase();
		while (sb.pixels_in < 400);

		for (int i = 0; i < DRAIN_LIMIT && sb.expected_pixels.size() != 0; i++)
			@(posedge clk);
		if (sb.expected_pixels.size() != 0) begin
			$error("%0d expected results never arrived", sb.expected_pixels.size());
			sb.mismatches++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Streamed %0d pixels in %0d frames, %0d results compared,",
			sb.pixels_in, sb.frames_seen, sb.results_seen);
		$display("frames from 3x3 up to 48 wide and 12 tall, sizes below 3 clamped.");
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/fns_pkg.sv
rtl/core/fns_orig_ram.sv
rtl/core/fns_smooth_ram.sv
rtl/core/fns_out_buf.sv
rtl/core/four_neighbour_smoothing_stream.sv
tb/sv/tb_four_neighbour_smoothing_stream.sv
